FILE: hw/rtl/pcb_pkg.sv
// ----------------------------------------------------------------------------
// pcb_pkg
// Shared types, constants and tables for the polar scan binner.
// ----------------------------------------------------------------------------
package pcb_pkg;

  // field widths
  localparam int COORD_BITS    = 24;
  localparam int RSQ_BITS      = 48;
  localparam int INT_BITS      = 16;
  localparam int ANG_BITS      = 16;
  localparam int BIN_IDX_BITS  = 9;
  localparam int RANGE_BITS    = 24;
  localparam int NUM_BINS_DEF  = 512;
  localparam int CORDIC_STEPS  = 15;
  localparam int CORDIC_BITS   = COORD_BITS + 3;
  localparam int SQRT_STEPS    = RSQ_BITS / 2;
  localparam int QUEUE_DEPTH   = 2;
  localparam int APB_ADDR_BITS = 5;
  localparam int APB_DATA_BITS = 64;

  // request codes
  localparam logic [1:0] REQ_CLEAR = 2'd0;
  localparam logic [1:0] REQ_ADD   = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  // register indexes
  localparam logic [1:0] REG_ANGLE_MIN    = 2'd0;
  localparam logic [1:0] REG_ANGLE_MAX    = 2'd1;
  localparam logic [1:0] REG_BIN_WIDTH    = 2'd2;
  localparam logic [1:0] REG_RANGE_MIN_SQ = 2'd3;

  // register reset values
  localparam logic signed [ANG_BITS-1:0] ANGLE_MIN_RST    = -16'sd32586;
  localparam logic signed [ANG_BITS-1:0] ANGLE_MAX_RST    = 16'sd32586;
  localparam logic [ANG_BITS-1:0]        BIN_WIDTH_RST    = 16'd182;
  localparam logic [RSQ_BITS-1:0]        RANGE_MIN_SQ_RST = 48'd10000;

  // empty marker and saturation ceiling of the squared range
  localparam logic [RSQ_BITS-1:0] RSQ_EMPTY = 48'hFFFF_FFFF_FFFF;
  localparam logic [RSQ_BITS-1:0] RSQ_MAX   = 48'hFFFF_FFFF_FFFE;

  typedef struct packed {
    logic [1:0]                   req_type;
    logic signed [COORD_BITS-1:0] x_mm;
    logic signed [COORD_BITS-1:0] y_mm;
    logic                         point_valid;
    logic [INT_BITS-1:0]          intensity;
    logic [BIN_IDX_BITS-1:0]      bin_index;
  } item_t;

  typedef struct packed {
    logic [RANGE_BITS-1:0] bin_range_mm;
    logic [INT_BITS-1:0]   bin_intensity;
    logic                  bin_empty;
  } result_t;

  typedef struct packed {
    logic signed [ANG_BITS-1:0] ang_lo;
    logic signed [ANG_BITS-1:0] ang_hi;
    logic [ANG_BITS-1:0]        bin_width;
    logic [RSQ_BITS-1:0]        range_min_sq;
  } cfg_t;

  // classified job passed from front to back
  typedef struct packed {
    logic [1:0]                   req_type;
    logic signed [COORD_BITS-1:0] x_mm;
    logic signed [COORD_BITS-1:0] y_mm;
    logic [INT_BITS-1:0]          intensity;
    logic [BIN_IDX_BITS-1:0]      bin_index;
    logic [RSQ_BITS-1:0]          rsq;
  } job_t;

  // atan(2^-i) in binary angle units, half turn 32768
  function automatic logic [ANG_BITS-1:0] atan_unit(input logic [3:0] i);
    logic [ANG_BITS-1:0] v;
    case (i)
      4'd0:    v = 16'd8192;
      4'd1:    v = 16'd4836;
      4'd2:    v = 16'd2555;
      4'd3:    v = 16'd1297;
      4'd4:    v = 16'd651;
      4'd5:    v = 16'd326;
      4'd6:    v = 16'd163;
      4'd7:    v = 16'd81;
      4'd8:    v = 16'd41;
      4'd9:    v = 16'd20;
      4'd10:   v = 16'd10;
      4'd11:   v = 16'd5;
      4'd12:   v = 16'd2;
      4'd13:   v = 16'd1;
      4'd14:   v = 16'd1;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

endpackage

FILE: hw/rtl/point_cloud_to_polar_scan_binner.sv
// ----------------------------------------------------------------------------
// point_cloud_to_polar_scan_binner
// Bins planar points by angle and keeps the nearest point of each bin.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive item and start; a request is taken at a clock edge
//   with start high and busy low. Requests are clear, add point and read bin.
//   Result channel: each read gives one result on result, marked by a single
//   cycle done strobe; it must be taken in that cycle. Clear and add give none.
//   Configuration: APB port, one 64-bit register every 8 bytes; write only
//   while the block is idle.
//   Timing: the front takes a request into stage s1, squares it into stage
//   s2, classifies it there and pushes surviving jobs into a two-entry
//   queue; busy is high the cycle after each transfer, so requests are never
//   taken back to back, and a full queue stalls the front. The back executes
//   one job at a time: an add runs 15 CORDIC steps, then, inside the angle
//   window, 16 divide steps and a read-modify-write of the bin store; a read
//   of a filled bin runs 24 square root steps and then S_EMIT, which raises
//   done; a clear sweeps the bin store one entry per cycle. Reset: registers
//   take their defaults and the bin store is cleared in a pass during which busy stays high.
// ----------------------------------------------------------------------------
module point_cloud_to_polar_scan_binner #(
  parameter int NUM_BINS = pcb_pkg::NUM_BINS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  pcb_pkg::item_t                    item,
  output logic                              done,
  output pcb_pkg::result_t                  result,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [pcb_pkg::APB_ADDR_BITS-1:0] paddr,
  input  logic [pcb_pkg::APB_DATA_BITS-1:0] pwdata,
  output logic [pcb_pkg::APB_DATA_BITS-1:0] prdata,
  output logic                              pready
);

  pcb_pkg::cfg_t cfg;
  logic          take;
  logic          front_busy;
  logic          init_busy;
  logic          push;
  pcb_pkg::job_t push_job;
  logic          q_full;
  logic          q_vld;
  pcb_pkg::job_t q_job;
  logic          pop;
  logic [1:0]    reg_idx;

  assign busy    = front_busy || init_busy;
  assign take    = start && !busy;
  assign pready  = 1'b1;
  assign reg_idx = paddr[pcb_pkg::APB_ADDR_BITS-1:3];

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ang_lo       <= pcb_pkg::ANGLE_MIN_RST;
      cfg.ang_hi       <= pcb_pkg::ANGLE_MAX_RST;
      cfg.bin_width    <= pcb_pkg::BIN_WIDTH_RST;
      cfg.range_min_sq <= pcb_pkg::RANGE_MIN_SQ_RST;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx)
        pcb_pkg::REG_ANGLE_MIN:    cfg.ang_lo       <= pwdata[15:0];
        pcb_pkg::REG_ANGLE_MAX:    cfg.ang_hi       <= pwdata[15:0];
        pcb_pkg::REG_BIN_WIDTH:    cfg.bin_width    <= pwdata[15:0];
        pcb_pkg::REG_RANGE_MIN_SQ: cfg.range_min_sq <= pwdata[pcb_pkg::RSQ_BITS-1:0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    case (reg_idx)
      pcb_pkg::REG_ANGLE_MIN:    prdata = 64'(unsigned'(cfg.ang_lo));
      pcb_pkg::REG_ANGLE_MAX:    prdata = 64'(unsigned'(cfg.ang_hi));
      pcb_pkg::REG_BIN_WIDTH:    prdata = 64'(cfg.bin_width);
      pcb_pkg::REG_RANGE_MIN_SQ: prdata = 64'(cfg.range_min_sq);
      default:                   prdata = '0;
    endcase
  end

  pcb_front u_front (
    .clk          (clk),
    .rst          (rst),
    .take         (take),
    .item         (item),
    .range_min_sq (cfg.range_min_sq),
    .q_full       (q_full),
    .front_busy   (front_busy),
    .push         (push),
    .push_job     (push_job)
  );

  pcb_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .q_full   (q_full),
    .q_vld    (q_vld),
    .q_job    (q_job)
  );

  pcb_back #(
    .NUM_BINS (NUM_BINS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_vld     (q_vld),
    .q_job     (q_job),
    .pop       (pop),
    .init_busy (init_busy),
    .done      (done),
    .result    (result)
  );

endmodule

FILE: hw/rtl/pcb_front.sv
// ----------------------------------------------------------------------------
// pcb_front
// Accepts requests, squares the point coordinates and drops points that are
// invalid or too near and requests of unknown type; pushes surviving jobs into the queue.
// ----------------------------------------------------------------------------
module pcb_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          take,
  input  pcb_pkg::item_t                item,
  input  logic [pcb_pkg::RSQ_BITS-1:0]  range_min_sq,
  input  logic                          q_full,
  output logic                          front_busy,
  output logic                          push,
  output pcb_pkg::job_t                 push_job
);

  localparam int CB = pcb_pkg::COORD_BITS;
  localparam int SB = 2 * pcb_pkg::COORD_BITS;

  logic           s1_vld;
  pcb_pkg::item_t s1_item;
  logic           s2_vld;
  pcb_pkg::item_t s2_item;
  logic [SB-1:0]  sq_x;
  logic [SB-1:0]  sq_y;
  logic [CB-1:0]  ax;
  logic [CB-1:0]  ay;
  logic [SB:0]    sum;
  logic [pcb_pkg::RSQ_BITS-1:0] rsq;
  logic           keep;
  logic           s1_go;
  logic           s2_go;

  // magnitudes of the coordinates
  always_comb begin
    ax = s1_item.x_mm[CB-1] ? CB'(-s1_item.x_mm) : CB'(s1_item.x_mm);
    ay = s1_item.y_mm[CB-1] ? CB'(-s1_item.y_mm) : CB'(s1_item.y_mm);
  end

  // squared range, saturated below the empty marker, and classification
  always_comb begin
    sum = {1'b0, sq_x} + {1'b0, sq_y};
    rsq = (sum > {1'b0, pcb_pkg::RSQ_MAX}) ? pcb_pkg::RSQ_MAX
                                           : sum[pcb_pkg::RSQ_BITS-1:0];
    case (s2_item.req_type)
      pcb_pkg::REQ_CLEAR: keep = 1'b1;
      pcb_pkg::REQ_READ:  keep = 1'b1;
      pcb_pkg::REQ_ADD:   keep = s2_item.point_valid && (rsq >= range_min_sq);
      default:            keep = 1'b0;
    endcase
  end

  assign s2_go      = s2_vld && !q_full;
  assign s1_go      = s1_vld && (!s2_vld || s2_go);
  assign push       = s2_go && keep;
  assign front_busy = s1_vld;

  always_comb begin
    push_job.req_type  = s2_item.req_type;
    push_job.x_mm      = s2_item.x_mm;
    push_job.y_mm      = s2_item.y_mm;
    push_job.intensity = s2_item.intensity;
    push_job.bin_index = s2_item.bin_index;
    push_job.rsq       = rsq;
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
    end else begin
      s1_vld <= take || (s1_vld && !s1_go);
      s2_vld <= s1_go || (s2_vld && !s2_go);
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    if (take) begin
      s1_item <= item;
    end
    if (s1_go) begin
      s2_item <= s1_item;
      sq_x    <= SB'(ax) * SB'(ax);
      sq_y    <= SB'(ay) * SB'(ay);
    end
  end

endmodule

FILE: hw/rtl/pcb_queue.sv
// ----------------------------------------------------------------------------
// pcb_queue
// Short job queue between the front and back parts.
// ----------------------------------------------------------------------------
module pcb_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  pcb_pkg::job_t push_job,
  input  logic          pop,
  output logic          q_full,
  output logic          q_vld,
  output pcb_pkg::job_t q_job
);

  localparam int D  = pcb_pkg::QUEUE_DEPTH;
  localparam int PW = (D > 1) ? $clog2(D) : 1;
  localparam int CW = $clog2(D + 1);

  pcb_pkg::job_t   slots [D];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;

  assign q_full = (count == CW'(D));
  assign q_vld  = (count != '0);
  assign q_job  = slots[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(D - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(D - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // hold the job
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

endmodule

FILE: hw/rtl/pcb_back.sv
// ----------------------------------------------------------------------------
// pcb_back
// Carries out jobs: clearing sweep, CORDIC angle, bin division, nearest-point
// update and the square root for bin reads.
// ----------------------------------------------------------------------------
module pcb_back #(
  parameter int NUM_BINS = pcb_pkg::NUM_BINS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  pcb_pkg::cfg_t    cfg,
  input  logic             q_vld,
  input  pcb_pkg::job_t    q_job,
  output logic             pop,
  output logic             init_busy,
  output logic             done,
  output pcb_pkg::result_t result
);

  localparam int AW = $clog2(NUM_BINS);
  localparam int CW = pcb_pkg::CORDIC_BITS;
  localparam int RB = pcb_pkg::RSQ_BITS;
  localparam int AB = pcb_pkg::ANG_BITS;
  localparam int IB = pcb_pkg::INT_BITS;

  typedef struct packed {
    logic [RB-1:0] rsq;
    logic [IB-1:0] intensity;
  } ent_t;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_ROT, S_WIN, S_DIV, S_CHK, S_AWAIT, S_UPD,
    S_RWAIT, S_RCHK, S_SQRT, S_EMIT
  } state_t;

  state_t               state;
  ent_t                 mem [NUM_BINS];
  ent_t                 rd_data;
  logic [AW-1:0]        addr_r;
  logic [AW-1:0]        clr_addr;
  logic                 we;
  logic [AW-1:0]        wa;
  ent_t                 wd;
  pcb_pkg::job_t        job_r;
  logic signed [CW-1:0] cx;
  logic signed [CW-1:0] cy;
  logic signed [CW-1:0] dx;
  logic signed [CW-1:0] dy;
  logic signed [CW-1:0] xe;
  logic signed [CW-1:0] ye;
  logic [AB-1:0]        acc;
  logic [4:0]           cnt;
  logic [AB:0]          rem;
  logic [AB-1:0]        dvd;
  logic [AB:0]          trial;
  logic                 ge;
  logic [RB-1:0]        sq_v;
  logic [RB-1:0]        sq_res;
  logic [RB-1:0]        sq_bit;
  logic [RB-1:0]        sq_sum;
  logic [IB-1:0]        rd_int;

  assign pop       = (state == S_IDLE) && q_vld;
  assign init_busy = (state == S_CLR) && job_r.req_type != pcb_pkg::REQ_CLEAR;

  // datapath helpers
  always_comb begin
    xe     = CW'(q_job.x_mm);
    ye     = CW'(q_job.y_mm);
    dx     = cy >>> cnt[3:0];
    dy     = cx >>> cnt[3:0];
    trial  = {rem[AB-1:0], dvd[AB-1]};
    ge     = trial >= {1'b0, cfg.bin_width};
    sq_sum = sq_res + sq_bit;
  end

  // memory write port
  always_comb begin
    we = 1'b0;
    wa = addr_r;
    wd = {job_r.rsq, job_r.intensity};
    case (state)
      S_CLR: begin
        we = 1'b1;
        wa = clr_addr;
        wd = {pcb_pkg::RSQ_EMPTY, {IB{1'b0}}};
      end
      S_UPD: begin
        we = rd_data.rsq > job_r.rsq;
      end
      default: ;
    endcase
  end

  // bin store
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data <= mem[addr_r];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_CLR;
      clr_addr       <= '0;
      done           <= 1'b0;
      job_r.req_type <= pcb_pkg::REQ_ADD;
    end else begin
      done <= 1'b0;
      case (state)
        S_CLR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(NUM_BINS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (q_vld) begin
            job_r <= q_job;
            case (q_job.req_type)
              pcb_pkg::REQ_CLEAR: begin
                clr_addr <= '0;
                state    <= S_CLR;
              end
              pcb_pkg::REQ_ADD: begin
                // pre-rotate the left half plane by a quarter turn
                if (xe < 0) begin
                  if (ye >= 0) begin
                    cx  <= ye;
                    cy  <= -xe;
                    acc <= 16'h4000;
                  end else begin
                    cx  <= -ye;
                    cy  <= xe;
                    acc <= 16'hC000;
                  end
                end else begin
                  cx  <= xe;
                  cy  <= ye;
                  acc <= '0;
                end
                cnt   <= '0;
                state <= S_ROT;
              end
              pcb_pkg::REQ_READ: begin
                if (32'(q_job.bin_index) >= 32'(NUM_BINS)) begin
                  done   <= 1'b1;
                  result <= '{bin_range_mm: '0, bin_intensity: '0, bin_empty: 1'b1};
                end else begin
                  addr_r <= AW'(q_job.bin_index);
                  state  <= S_RWAIT;
                end
              end
              default: ;
            endcase
          end
        end
        S_ROT: begin
          if (cy < 0) begin
            cx  <= cx - dx;
            cy  <= cy + dy;
            acc <= acc - pcb_pkg::atan_unit(cnt[3:0]);
          end else begin
            cx  <= cx + dx;
            cy  <= cy - dy;
            acc <= acc + pcb_pkg::atan_unit(cnt[3:0]);
          end
          cnt <= cnt + 1'b1;
          if (cnt == 5'(pcb_pkg::CORDIC_STEPS - 1)) begin
            state <= S_WIN;
          end
        end
        S_WIN: begin
          // drop outside the angle window or with zero bin width
          if ($signed(acc) < cfg.ang_lo || $signed(acc) > cfg.ang_hi ||
              cfg.bin_width == '0) begin
            state <= S_IDLE;
          end else begin
            dvd   <= AB'(acc - cfg.ang_lo);
            rem   <= '0;
            cnt   <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          rem <= ge ? (trial - {1'b0, cfg.bin_width}) : trial;
          dvd <= {dvd[AB-2:0], ge};
          cnt <= cnt + 1'b1;
          if (cnt == 5'(AB - 1)) begin
            state <= S_CHK;
          end
        end
        S_CHK: begin
          if (32'(dvd) >= 32'(NUM_BINS)) begin
            state <= S_IDLE;
          end else begin
            addr_r <= AW'(dvd);
            state  <= S_AWAIT;
          end
        end
        S_AWAIT: begin
          state <= S_UPD;
        end
        S_UPD: begin
          state <= S_IDLE;
        end
        S_RWAIT: begin
          state <= S_RCHK;
        end
        S_RCHK: begin
          if (rd_data.rsq == pcb_pkg::RSQ_EMPTY) begin
            done   <= 1'b1;
            result <= '{bin_range_mm: '0, bin_intensity: '0, bin_empty: 1'b1};
            state  <= S_IDLE;
          end else begin
            sq_v   <= rd_data.rsq;
            sq_res <= '0;
            sq_bit <= {2'b01, {(RB - 2){1'b0}}};
            rd_int <= rd_data.intensity;
            cnt    <= '0;
            state  <= S_SQRT;
          end
        end
        S_SQRT: begin
          // one result bit per step
          if (sq_v >= sq_sum) begin
            sq_v   <= sq_v - sq_sum;
            sq_res <= (sq_res >> 1) + sq_bit;
          end else begin
            sq_res <= sq_res >> 1;
          end
          sq_bit <= sq_bit >> 2;
          cnt    <= cnt + 1'b1;
          if (cnt == 5'(pcb_pkg::SQRT_STEPS - 1)) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          done   <= 1'b1;
          result <= '{bin_range_mm: sq_res[pcb_pkg::RANGE_BITS-1:0],
                      bin_intensity: rd_int, bin_empty: 1'b0};
          state  <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: hw/rtl/pcb_checker.sv
// ----------------------------------------------------------------------------
// pcb_checker
// Port-level checks on the polar scan binner, bound to the top level.
// ----------------------------------------------------------------------------
module pcb_checker (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input logic             done,
  input pcb_pkg::result_t result,
  input logic             pready
);

  // reset starts the clearing pass and silences results
  a_reset_busy: assert property (@(posedge clk) rst |=> busy && !done)
    else $error("binner not busy or strobing after reset");

  // a transfer raises busy, so requests are never taken back to back
  a_take_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("request taken back to back");

  // an empty bin reads as zero range and intensity
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.bin_empty) |->
      (result.bin_range_mm == '0 && result.bin_intensity == '0))
    else $error("empty bin with nonzero payload");

  // configuration port never waits
  a_pready: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready low");

endmodule

bind point_cloud_to_polar_scan_binner pcb_checker u_chk (.*);

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the polar scan binner: drives clear, add and read
// requests under several register settings, predicts each bin readout from
// a local model of the bin store and compares every read result field by
// field.
// ----------------------------------------------------------------------------
module tb;
  import pcb_pkg::*;

  // nearest-point bin store and its expected readouts
  class bin_scoreboard;
    logic [RSQ_BITS-1:0]        near_rsq [NUM_BINS_DEF];
    logic [INT_BITS-1:0]        near_int [NUM_BINS_DEF];
    logic signed [ANG_BITS-1:0] amin, amax;
    logic [ANG_BITS-1:0]        bwidth;
    logic [RSQ_BITS-1:0]        rmin_sq;
    result_t                    readouts[$];
    int                         errors;

    function new();
      amin    = ANGLE_MIN_RST;
      amax    = ANGLE_MAX_RST;
      bwidth  = BIN_WIDTH_RST;
      rmin_sq = RANGE_MIN_SQ_RST;
      errors  = 0;
      wipe();
    endfunction

    function void wipe();
      for (int b = 0; b < NUM_BINS_DEF; b++) begin
        near_rsq[b] = RSQ_EMPTY;
        near_int[b] = '0;
      end
    endfunction

    function void set_reg(logic [1:0] idx, logic [63:0] v);
      case (idx)
        REG_ANGLE_MIN:    amin    = v[ANG_BITS-1:0];
        REG_ANGLE_MAX:    amax    = v[ANG_BITS-1:0];
        REG_BIN_WIDTH:    bwidth  = v[ANG_BITS-1:0];
        REG_RANGE_MIN_SQ: rmin_sq = v[RSQ_BITS-1:0];
        default: ;
      endcase
    endfunction

    // vectoring CORDIC giving a binary angle, half turn 32768
    function logic signed [ANG_BITS-1:0] bearing(longint signed x, longint signed y);
      int unsigned step_ang [CORDIC_STEPS] = '{8192, 4836, 2555, 1297, 651, 326, 163,
                                               81, 41, 20, 10, 5, 2, 1, 1};
      longint signed acc, t, dx, dy;
      acc = 0;
      if (x < 0) begin
        t = x;
        if (y >= 0) begin
          x = y; y = -t; acc = 16384;
        end else begin
          x = -y; y = t; acc = -16384;
        end
      end
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y < 0) begin
          x -= dx; y += dy; acc -= step_ang[i];
        end else begin
          x += dx; y -= dy; acc += step_ang[i];
        end
      end
      return acc[ANG_BITS-1:0];
    endfunction

    function logic [RSQ_BITS-1:0] dist_sq(item_t it);
      longint signed x, y;
      longint unsigned s;
      x = it.x_mm;
      y = it.y_mm;
      s = x * x + y * y;
      if (s > RSQ_MAX) s = RSQ_MAX;
      return s[RSQ_BITS-1:0];
    endfunction

    // bin the point lands in, or -1 when it is dropped
    function int landing_bin(item_t it);
      logic signed [ANG_BITS-1:0] ang;
      int unsigned off, idx;
      if (!it.point_valid) return -1;
      if (dist_sq(it) < rmin_sq) return -1;
      ang = bearing(it.x_mm, it.y_mm);
      if (ang < amin || ang > amax) return -1;
      if (bwidth == 0) return -1;
      off = int'(ang) - int'(amin);
      idx = off / bwidth;
      if (idx >= NUM_BINS_DEF) return -1;
      return idx;
    endfunction

    function logic [RANGE_BITS-1:0] root(logic [RSQ_BITS-1:0] v);
      longint unsigned rem, res, b;
      rem = v; res = 0; b = 64'd1 << 46;
      while (b > rem) b >>= 2;
      while (b != 0) begin
        if (rem >= res + b) begin
          rem -= res + b;
          res = (res >> 1) + b;
        end else begin
          res >>= 1;
        end
        b >>= 2;
      end
      return res[RANGE_BITS-1:0];
    endfunction

    // note an accepted request
    function void note_request(item_t it);
      int b;
      result_t r;
      case (it.req_type)
        REQ_CLEAR: wipe();
        REQ_ADD: begin
          b = landing_bin(it);
          if (b >= 0 && near_rsq[b] > dist_sq(it)) begin
            near_rsq[b] = dist_sq(it);
            near_int[b] = it.intensity;
          end
        end
        REQ_READ: begin
          if (it.bin_index >= NUM_BINS_DEF || near_rsq[it.bin_index] == RSQ_EMPTY) begin
            r = '{bin_range_mm: '0, bin_intensity: '0, bin_empty: 1'b1};
          end else begin
            r.bin_range_mm  = root(near_rsq[it.bin_index]);
            r.bin_intensity = near_int[it.bin_index];
            r.bin_empty     = 1'b0;
          end
          readouts.push_back(r);
        end
        default: ;
      endcase
    endfunction

    // compare a read result with the oldest expected readout
    function void check_readout(result_t got);
      result_t exp_r;
      if (readouts.size() == 0) begin
        $error("unexpected result %p", got);
        errors++;
        return;
      end
      exp_r = readouts.pop_front();
      if (got.bin_range_mm !== exp_r.bin_range_mm) begin
        $error("bin_range_mm expected %0d got %0d", exp_r.bin_range_mm, got.bin_range_mm);
        errors++;
      end
      if (got.bin_intensity !== exp_r.bin_intensity) begin
        $error("bin_intensity expected %0d got %0d", exp_r.bin_intensity, got.bin_intensity);
        errors++;
      end
      if (got.bin_empty !== exp_r.bin_empty) begin
        $error("bin_empty expected %0b got %0b", exp_r.bin_empty, got.bin_empty);
        errors++;
      end
    endfunction
  endclass

  logic                     clk, rst, start, busy, done;
  item_t                    item;
  result_t                  result;
  logic                     psel, penable, pwrite, pready;
  logic [APB_ADDR_BITS-1:0] paddr;
  logic [APB_DATA_BITS-1:0] pwdata, prdata;

  bin_scoreboard sb = new();
  int            gap_pct;
  int            sent;
  int            recent_bins[$];

  point_cloud_to_polar_scan_binner DUT (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // take every read transfer
  always @(posedge clk) begin
    if (!rst && done) sb.check_readout(result);
  end

  // register write: setup cycle then access cycle
  task automatic reg_write(logic [1:0] idx, logic [63:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_BITS'(idx) << 3;
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_reg(idx, v);
  endtask

  // hold the request until the block takes it, then maybe idle
  task automatic send(item_t it);
    start <= 1'b1;
    item  <= it;
    do @(posedge clk); while (busy);
    sb.note_request(it);
    if (it.req_type == REQ_ADD) begin
      if (sb.landing_bin(it) >= 0) recent_bins.push_back(sb.landing_bin(it));
      if (recent_bins.size() > 16) void'(recent_bins.pop_front());
    end
    sent++;
    if ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  // drain outstanding work, then reprogram all registers
  task automatic configure(int amin, int amax, int bw, longint unsigned rmin);
    start <= 1'b0;
    while (sb.readouts.size() != 0) @(posedge clk);
    repeat (3000) @(posedge clk);
    reg_write(REG_ANGLE_MIN, 64'(amin));
    reg_write(REG_ANGLE_MAX, 64'(amax));
    reg_write(REG_BIN_WIDTH, 64'(bw));
    reg_write(REG_RANGE_MIN_SQ, 64'(rmin));
  endtask

  function automatic item_t make(logic [1:0] rq, int x, int y, logic v, int inten, int b);
    item_t it;
    it.req_type    = rq;
    it.x_mm        = COORD_BITS'(x);
    it.y_mm        = COORD_BITS'(y);
    it.point_valid = v;
    it.intensity   = INT_BITS'(inten);
    it.bin_index   = BIN_IDX_BITS'(b);
    return it;
  endfunction

  function automatic int coord();
    int sh;
    sh = $urandom_range(0, 23);
    return $signed($urandom) >>> (31 - sh);
  endfunction

  function automatic item_t random_item();
    item_t it;
    int    p;
    it = make(REQ_ADD, coord(), coord(), $urandom_range(99) < 95,
              $urandom_range(0, 65535), $urandom_range(0, 511));
    p = $urandom_range(99);
    if (p < 3) begin
      it.req_type = REQ_CLEAR;
    end else if (p < 5) begin
      it.req_type = 2'd3;
    end else if (p < 35) begin
      it.req_type = REQ_READ;
      if (recent_bins.size() > 0 && $urandom_range(3) != 0)
        it.bin_index = recent_bins[$urandom_range(0, recent_bins.size() - 1)];
    end else if (p < 45 && recent_bins.size() > 0) begin
      // add a random point with both coordinates shifted right by four
      it = make(REQ_ADD, coord() >>> 4, coord() >>> 4, 1'b1, $urandom_range(0, 65535), 0);
    end
    return it;
  endfunction

  task automatic random_run(int n);
    repeat (n) begin
      gap_pct = (sent < 617) ? 10 : (sent < 1234) ? 51 : 0;
      send(random_item());
    end
  endtask

  // directed corners under reset settings
  task automatic directed_run();
    item_t pts[$];
    pts.push_back(make(REQ_ADD, 8388607, 0, 1'b1, 65535, 0));
    pts.push_back(make(REQ_ADD, -8388608, -8388608, 1'b1, 1, 0));
    pts.push_back(make(REQ_ADD, 0, 8388607, 1'b1, 4660, 0));
    pts.push_back(make(REQ_ADD, 3000, -4000, 1'b1, 100, 0));
    pts.push_back(make(REQ_ADD, 3000, -4000, 1'b1, 200, 0));
    pts.push_back(make(REQ_ADD, 2999, -3999, 1'b1, 300, 0));
    pts.push_back(make(REQ_ADD, -5000, 0, 1'b1, 7, 0));
    pts.push_back(make(REQ_ADD, 50, 50, 1'b1, 8, 0));
    pts.push_back(make(REQ_ADD, 6000, 6000, 1'b0, 9, 0));
    gap_pct = 10;
    send(make(REQ_CLEAR, 0, 0, 1'b0, 0, 0));
    send(make(REQ_READ, 0, 0, 1'b0, 0, 0));
    send(make(REQ_READ, 0, 0, 1'b0, 0, 511));
    foreach (pts[i]) send(pts[i]);
    foreach (pts[i]) begin
      if (sb.landing_bin(pts[i]) >= 0)
        send(make(REQ_READ, 0, 0, 1'b0, 0, sb.landing_bin(pts[i])));
    end
    send(make(2'd3, -1, -1, 1'b1, 65535, 511));
    send(make(REQ_CLEAR, 0, 0, 1'b0, 0, 0));
    send(make(REQ_READ, 0, 0, 1'b0, 0, sb.landing_bin(pts[3])));
  endtask

  initial begin
    rst     = 1'b1;
    start   = 1'b0;
    item    = '0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    sent    = 0;
    gap_pct = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    wait (!busy);
    @(posedge clk);
    configure(-32586, 32586, 182, 10000);
    directed_run();
    random_run(380);
    configure(-32768, 32767, 1, 0);
    random_run(380);
    configure(-32768, 32767, 65535, 64'd140737488355328);
    random_run(200);
    configure(-1000, 1000, 4, 1);
    random_run(380);
    configure(16000, -16000, 0, 0);
    random_run(60);
    configure(-20000, 32767, 120, 2500);
    random_run(430);
    start <= 1'b0;
    while (sb.readouts.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.errors == 0) begin
      $display("point_cloud_to_polar_scan_binner verification clean");
    end else begin
      $display("point_cloud_to_polar_scan_binner verification failed");
    end
    $finish;
  end

  // hard stop
  initial begin
    #50ms;
    $display("point_cloud_to_polar_scan_binner verification failed");
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/pcb_pkg.sv
hw/rtl/pcb_front.sv
hw/rtl/pcb_queue.sv
hw/rtl/pcb_back.sv
hw/rtl/point_cloud_to_polar_scan_binner.sv
hw/rtl/pcb_checker.sv
tb/tb.sv
